[sv/rfsp_pkg.sv]
`default_nettype none

package rfsp_pkg;

    // Largest sprite edge the datapath is sized for.
    localparam int MAX_MAP_SIZE = 256;

    localparam int MAP_SIZE_W = 9;
    localparam int COORD_W    = 8;
    localparam int PIX_W      = 8;

    // Effective edge length and |2*coord - N| both fit in N_W bits.
    localparam int N_W     = $clog2(MAX_MAP_SIZE) + 1;
    localparam int DIFF_W  = N_W;
    localparam int CMP_W   = ((N_W > COORD_W + 1) ? N_W : COORD_W + 1) + 1;

    // Squared distance in half-pixel units and the square root in Q16.
    localparam int S_W        = 2 * DIFF_W;
    localparam int FRAC_SHIFT = 32;
    localparam int ROOT_W     = (S_W + FRAC_SHIFT) / 2;
    localparam int REM_W      = ROOT_W + 2;

    // Distance after the divide, Q1.16: one integer bit and 16 fraction bits.
    localparam int Q_W    = 17;
    localparam int T_W    = Q_W + 1;
    localparam int D2_W   = 2 * Q_W;
    localparam int PP_W   = Q_W + T_W;
    localparam int PROD_W = 49;
    localparam int F_W    = 49;
    localparam int FS_W   = F_W + 8;

    localparam logic [MAP_SIZE_W-1:0] MAP_SIZE_RESET = MAP_SIZE_W'(32);
    localparam logic [N_W-1:0]        MIN_N          = N_W'(2);
    localparam logic [N_W-1:0]        MAX_N          = N_W'(MAX_MAP_SIZE);
    localparam logic [Q_W-1:0]        ONE_Q16        = Q_W'(65536);
    localparam logic [T_W-1:0]        THREE_Q16      = T_W'(3 * 65536);
    localparam logic [F_W-1:0]        ONE_Q48        = F_W'(1) << 48;

    typedef struct packed {
        logic                valid;
        logic                oob;
        logic [DIFF_W-1:0]   dx;
        logic [DIFF_W-1:0]   dy;
    } t_delta_beat;

    typedef struct packed {
        logic                valid;
        logic                oob;
        logic [S_W-1:0]      s;
    } t_prep_beat;

    typedef struct packed {
        logic                valid;
        logic                oob;
        logic [S_W-1:0]      s;
        logic [REM_W-1:0]    rem;
        logic [ROOT_W-1:0]   root;
    } t_sqrt_beat;

    typedef struct packed {
        logic                valid;
        logic                oob;
        logic                big;
        logic [ROOT_W-1:0]   root;
        logic [N_W-1:0]      rem;
        logic [Q_W-1:0]      q;
    } t_div_beat;

    typedef struct packed {
        logic                valid;
        logic [PIX_W-1:0]    intensity;
    } t_pix_beat;

endpackage

`default_nettype wire

[sv/rfsp_prep.sv]
`default_nettype none

module rfsp_prep (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_ce,
    input  wire logic                           i_valid,
    input  wire logic [rfsp_pkg::COORD_W-1:0]   i_col,
    input  wire logic [rfsp_pkg::COORD_W-1:0]   i_row,
    input  wire logic [rfsp_pkg::N_W-1:0]       i_n,
    output rfsp_pkg::t_prep_beat                o_beat
);

    rfsp_pkg::t_delta_beat r_delta;
    rfsp_pkg::t_delta_beat n_delta;
    rfsp_pkg::t_prep_beat  r_prep;
    rfsp_pkg::t_prep_beat  n_prep;

    logic [rfsp_pkg::CMP_W-1:0] two_col;
    logic [rfsp_pkg::CMP_W-1:0] two_row;
    logic [rfsp_pkg::CMP_W-1:0] n_ext;
    logic [rfsp_pkg::CMP_W-1:0] dx_full;
    logic [rfsp_pkg::CMP_W-1:0] dy_full;
    logic                       oob;
    logic [rfsp_pkg::S_W-1:0]   sq_x;
    logic [rfsp_pkg::S_W-1:0]   sq_y;

    // Stage one: distance from the center on each axis, in half-pixel units.
    always_comb begin
        n_ext   = rfsp_pkg::CMP_W'(i_n);
        two_col = rfsp_pkg::CMP_W'(i_col) << 1;
        two_row = rfsp_pkg::CMP_W'(i_row) << 1;
        oob     = (rfsp_pkg::CMP_W'(i_col) >= n_ext) || (rfsp_pkg::CMP_W'(i_row) >= n_ext);
        dx_full = (two_col >= n_ext) ? (two_col - n_ext) : (n_ext - two_col);
        dy_full = (two_row >= n_ext) ? (two_row - n_ext) : (n_ext - two_row);

        n_delta.valid = i_valid;
        n_delta.oob   = oob;
        n_delta.dx    = oob ? '0 : rfsp_pkg::DIFF_W'(dx_full);
        n_delta.dy    = oob ? '0 : rfsp_pkg::DIFF_W'(dy_full);
    end

    // Stage two: squared radius.
    always_comb begin
        sq_x         = r_delta.dx * r_delta.dx;
        sq_y         = r_delta.dy * r_delta.dy;
        n_prep.valid = r_delta.valid;
        n_prep.oob   = r_delta.oob;
        n_prep.s     = sq_x + sq_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta.valid <= 1'b0;
            r_prep.valid  <= 1'b0;
        end else if (i_ce) begin
            r_delta <= n_delta;
            r_prep  <= n_prep;
        end
    end

    assign o_beat = r_prep;

endmodule

`default_nettype wire

[sv/rfsp_isqrt.sv]
`default_nettype none

module rfsp_isqrt (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_ce,
    input  wire rfsp_pkg::t_prep_beat i_beat,
    output rfsp_pkg::t_sqrt_beat     o_beat
);

    localparam int STAGES = rfsp_pkg::ROOT_W;

    rfsp_pkg::t_sqrt_beat r_st [STAGES];
    rfsp_pkg::t_sqrt_beat n_st [STAGES];

    // One result bit per stage: the radicand is s shifted up by FRAC_SHIFT,
    // so the low pairs of radicand bits are all zero.
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int PAIR = STAGES - 1 - k;

        rfsp_pkg::t_sqrt_beat         src;
        logic [1:0]                   pair_bits;
        logic [rfsp_pkg::REM_W+1:0]   cand;
        logic [rfsp_pkg::REM_W+1:0]   trial;

        if (k == 0) begin : g_first
            always_comb begin
                src       = '0;
                src.valid = i_beat.valid;
                src.oob   = i_beat.oob;
                src.s     = i_beat.s;
            end
        end else begin : g_next
            assign src = r_st[k-1];
        end

        if (2 * PAIR >= rfsp_pkg::FRAC_SHIFT) begin : g_sbits
            assign pair_bits = src.s[2*PAIR-rfsp_pkg::FRAC_SHIFT +: 2];
        end else begin : g_zbits
            assign pair_bits = 2'b00;
        end

        always_comb begin
            cand  = {src.rem, pair_bits};
            trial = {2'b00, src.root, 2'b01};
            n_st[k] = src;
            if (cand >= trial) begin
                n_st[k].rem  = rfsp_pkg::REM_W'(cand - trial);
                n_st[k].root = {src.root[rfsp_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_st[k].rem  = rfsp_pkg::REM_W'(cand);
                n_st[k].root = {src.root[rfsp_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].valid <= 1'b0;
            end else if (i_ce) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_beat = r_st[STAGES-1];

endmodule

`default_nettype wire

[sv/rfsp_div.sv]
`default_nettype none

module rfsp_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_ce,
    input  wire logic [rfsp_pkg::N_W-1:0]   i_n,
    input  wire rfsp_pkg::t_sqrt_beat       i_beat,
    output rfsp_pkg::t_div_beat             o_beat
);

    localparam int STAGES = rfsp_pkg::Q_W;

    rfsp_pkg::t_div_beat r_entry;
    rfsp_pkg::t_div_beat n_entry;
    rfsp_pkg::t_div_beat r_st [STAGES];
    rfsp_pkg::t_div_beat n_st [STAGES];

    // A root of N * 2^17 or more gives a quotient past one, which saturates
    // anyway, so only 17 quotient bits are developed. Otherwise the top root
    // bits are already below N and seed the partial remainder.
    always_comb begin
        n_entry.valid = i_beat.valid;
        n_entry.oob   = i_beat.oob;
        n_entry.root  = i_beat.root;
        n_entry.big   = ({1'b0, i_beat.root} >= {i_n, rfsp_pkg::Q_W'(0)});
        n_entry.rem   = rfsp_pkg::N_W'(i_beat.root[rfsp_pkg::ROOT_W-1:rfsp_pkg::Q_W]);
        n_entry.q     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_ce) begin
            r_entry <= n_entry;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int BIT = STAGES - 1 - k;

        rfsp_pkg::t_div_beat          src;
        logic [rfsp_pkg::N_W:0]       cand;

        if (k == 0) begin : g_first
            assign src = r_entry;
        end else begin : g_next
            assign src = r_st[k-1];
        end

        always_comb begin
            cand    = {src.rem, src.root[BIT]};
            n_st[k] = src;
            if (cand >= {1'b0, i_n}) begin
                n_st[k].rem = rfsp_pkg::N_W'(cand - {1'b0, i_n});
                n_st[k].q   = {src.q[rfsp_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_st[k].rem = rfsp_pkg::N_W'(cand);
                n_st[k].q   = {src.q[rfsp_pkg::Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].valid <= 1'b0;
            end else if (i_ce) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_beat = r_st[STAGES-1];

endmodule

`default_nettype wire

[sv/rfsp_poly.sv]
`default_nettype none

module rfsp_poly (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_ce,
    input  wire rfsp_pkg::t_div_beat i_beat,
    output rfsp_pkg::t_pix_beat      o_beat
);

    logic                              r_v1, r_v2, r_v3, r_v4, r_v5;
    logic                              r_oob1, r_oob2, r_oob3, r_oob4;
    logic [rfsp_pkg::D2_W-1:0]         r_d2;
    logic [rfsp_pkg::T_W-1:0]          r_t;
    logic [rfsp_pkg::PP_W-1:0]         r_p_hi;
    logic [rfsp_pkg::PP_W-1:0]         r_p_lo;
    logic [rfsp_pkg::PROD_W-1:0]       r_prod;
    logic [rfsp_pkg::F_W-1:0]          r_f;
    logic [rfsp_pkg::PIX_W-1:0]        r_val;

    logic [rfsp_pkg::Q_W-1:0]          d;
    logic [rfsp_pkg::D2_W-1:0]         n_d2;
    logic [rfsp_pkg::T_W-1:0]          n_t;
    logic [rfsp_pkg::PP_W-1:0]         n_p_hi;
    logic [rfsp_pkg::PP_W-1:0]         n_p_lo;
    logic [rfsp_pkg::PROD_W-1:0]       n_prod;
    logic [rfsp_pkg::F_W-1:0]          n_f;
    logic [rfsp_pkg::FS_W-1:0]         f_scaled;
    logic [rfsp_pkg::PIX_W-1:0]        n_val;

    // f = 2^48 - d^2 * (3*2^16 - 2d); d^2 is split in halves so that each
    // product stays near 17 by 18 bits.
    always_comb begin
        d = (i_beat.big || (i_beat.q > rfsp_pkg::ONE_Q16)) ? rfsp_pkg::ONE_Q16 : i_beat.q;
        n_d2   = d * d;
        n_t    = rfsp_pkg::THREE_Q16 - {d, 1'b0};
        n_p_hi = r_d2[rfsp_pkg::D2_W-1:rfsp_pkg::Q_W] * r_t;
        n_p_lo = r_d2[rfsp_pkg::Q_W-1:0] * r_t;
        n_prod = rfsp_pkg::PROD_W'({r_p_hi, rfsp_pkg::Q_W'(0)}) + rfsp_pkg::PROD_W'(r_p_lo);
        n_f    = rfsp_pkg::ONE_Q48 - r_prod;
        f_scaled = {r_f, 8'h00} - rfsp_pkg::FS_W'(r_f);
        n_val  = r_oob4 ? '0 : f_scaled[55:48];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_beat.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_oob1 <= i_beat.oob;
            r_oob2 <= r_oob1;
            r_oob3 <= r_oob2;
            r_oob4 <= r_oob3;
            r_d2   <= n_d2;
            r_t    <= n_t;
            r_p_hi <= n_p_hi;
            r_p_lo <= n_p_lo;
            r_prod <= n_prod;
            r_f    <= n_f;
            r_val  <= n_val;
        end
    end

    assign o_beat.valid     = r_v5;
    assign o_beat.intensity = r_val;

endmodule

`default_nettype wire

[sv/radial_falloff_sprite_pixel_core.sv]
// Radial falloff sprite: intensity of one pixel of an N by N sprite whose
// brightness falls from 255 at the center to 0 at the inscribed circle.
//
// Input channel s_axis: one beat per pixel, tdata = {row, col}. Output channel
// m_axis: one beat per input beat, in order, tdata = intensity.
// Pixels with col or row at or beyond N give 0.
// The edge length N is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while no pixel is in flight; the block has no check for it.
// Values below 2 or above 256 act as 2 and 256.
//
// An accepted beat passes two stages that form the squared radius, 25 stages
// that produce the square root one bit each, 18 stages that divide by N (a
// seed stage, then one quotient bit each), five stages that evaluate the
// cubic, and the output register. Throughput is one pixel per cycle while
// the skid register is empty. When the receiver stalls, an output register
// plus one skid register absorb the pipeline's next result, and the whole
// pipeline then holds until the skid register drains; s_axis_tready is the
// inverse of r_skid_valid. Reset clears every valid bit and sets N to 32.
`default_nettype none

module radial_falloff_sprite_pixel_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rfsp_pkg::MAP_SIZE_W-1:0]     i_cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output wire logic                                s_axis_tready,
    input  wire logic [2*rfsp_pkg::COORD_W-1:0]      s_axis_tdata,   // {row, col}
    output wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output wire logic [rfsp_pkg::PIX_W-1:0]          m_axis_tdata    // intensity
);

    logic [rfsp_pkg::N_W-1:0]    r_n;
    logic [rfsp_pkg::N_W-1:0]    n_n;
    logic                        r_out_valid;
    logic [rfsp_pkg::PIX_W-1:0]  r_out_data;
    logic                        r_skid_valid;
    logic [rfsp_pkg::PIX_W-1:0]  r_skid_data;

    logic                        ce;
    logic                        out_take;

    rfsp_pkg::t_prep_beat        prep_beat;
    rfsp_pkg::t_sqrt_beat        sqrt_beat;
    rfsp_pkg::t_div_beat         div_beat;
    rfsp_pkg::t_pix_beat         pix_beat;

    always_comb begin
        if (32'(i_cfg_wdata) < 32'(rfsp_pkg::MIN_N)) begin
            n_n = rfsp_pkg::MIN_N;
        end else if (32'(i_cfg_wdata) > rfsp_pkg::MAX_MAP_SIZE) begin
            n_n = rfsp_pkg::MAX_N;
        end else begin
            n_n = rfsp_pkg::N_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= rfsp_pkg::N_W'(rfsp_pkg::MAP_SIZE_RESET);
        end else if (i_cfg_we) begin
            r_n <= n_n;
        end
    end

    assign ce       = !r_skid_valid;
    assign out_take = r_out_valid && m_axis_tready;

    rfsp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_axis_tvalid),
        .i_col   (s_axis_tdata[rfsp_pkg::COORD_W-1:0]),
        .i_row   (s_axis_tdata[2*rfsp_pkg::COORD_W-1:rfsp_pkg::COORD_W]),
        .i_n     (r_n),
        .o_beat  (prep_beat)
    );

    rfsp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_beat  (prep_beat),
        .o_beat  (sqrt_beat)
    );

    rfsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_n     (r_n),
        .i_beat  (sqrt_beat),
        .o_beat  (div_beat)
    );

    rfsp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_beat  (div_beat),
        .o_beat  (pix_beat)
    );

    // The last pipeline stage leaves whenever the pipeline advances; if the
    // output register is still held, the beat parks in the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (pix_beat.valid) begin
            if (!r_out_valid || out_take) begin
                r_out_data  <= pix_beat.intensity;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= pix_beat.intensity;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = ce;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
